/* hw/rtl/nsf_pkg.sv */
// Shared types, codes and helpers for the NMEA sentence framer.
`timescale 1ns / 1ps
package nsf_pkg;

  localparam int unsigned NSF_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_BODY  = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_BODY = 2'd1,
    CMD_END  = 2'd2
  } cmd_kind_t;

  // One queued command: header fields, body byte or finished checksum.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] talker;
    logic [23:0] sentence;
    logic [7:0]  ch;
  } cmd_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;

  localparam logic [2:0] HDR_LAST_IDX = 3'd6;
  localparam logic [2:0] END_LAST_IDX = 3'd4;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/nmea_sentence_framer.sv */
// NMEA 0183 sentence framer, top level.
//
// Input channel (in_valid/in_ready): one item per transfer. action selects
// begin (talker_chars, sentence_chars used), body (body_char used) or end.
// Body and end items with no sentence open, and the unused action code, are
// taken and produce nothing.
// Output channel (out_valid/out_ready): one byte of the framed sentence per
// transfer; run_last marks the final byte caused by an item.
// Begin yields 7 bytes ($, header, comma), body 1 byte, end 5 bytes
// (*, two hex checksum digits, CR, LF). The back end emits one byte per
// cycle while out_ready is high, so body items then sustain one per cycle.
// An item is written into the queue; its bytes are then registered at the output.
// A command queue of QueueDepth entries sits between the front end and the
// byte serialiser; in_ready drops only while it is full, so a stalled
// receiver backs up into the queue and then the input channel.
// Reset clears the queue, out_valid, the byte index and any open sentence.
`timescale 1ns / 1ps
module nmea_sentence_framer #(
  parameter int unsigned QueueDepth = nsf_pkg::NSF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] talker_chars,
  input  logic [23:0] sentence_chars,
  input  logic [7:0]  body_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        run_last
);
  import nsf_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_data;
  cmd_t q_head;

  nsf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .talker_chars   (talker_chars),
    .sentence_chars (sentence_chars),
    .body_char      (body_char),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_data)
  );

  nsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  nsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .run_last  (run_last)
  );

endmodule

/* hw/rtl/nsf_front.sv */
// Front end: accepts items, tracks sentence state and checksum, queues commands.
`timescale 1ns / 1ps
module nsf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [15:0]        talker_chars,
  input  logic [23:0]        sentence_chars,
  input  logic [7:0]         body_char,
  input  logic               q_full,
  output logic               q_push,
  output nsf_pkg::cmd_t      q_data
);
  import nsf_pkg::*;

  logic       in_sentence;
  logic       in_sentence_next;
  logic [7:0] running_xor;
  logic [7:0] running_xor_next;
  logic       accept;
  logic       push_req;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && push_req;

  always_comb begin
    push_req         = 1'b0;
    in_sentence_next = in_sentence;
    running_xor_next = running_xor;
    q_data.kind      = CMD_BODY;
    q_data.talker    = talker_chars;
    q_data.sentence  = sentence_chars;
    q_data.ch        = body_char;
    unique case (action)
      ACT_BEGIN: begin
        push_req         = 1'b1;
        q_data.kind      = CMD_HDR;
        in_sentence_next = 1'b1;
        running_xor_next = talker_chars[15:8] ^ talker_chars[7:0] ^
                           sentence_chars[23:16] ^ sentence_chars[15:8] ^
                           sentence_chars[7:0] ^ CH_COMMA;
      end
      ACT_BODY: begin
        if (in_sentence) begin
          push_req         = 1'b1;
          running_xor_next = running_xor ^ body_char;
        end
      end
      ACT_END: begin
        if (in_sentence) begin
          push_req         = 1'b1;
          q_data.kind      = CMD_END;
          q_data.ch        = running_xor;
          in_sentence_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      running_xor <= 8'd0;
    end else if (accept) begin
      in_sentence <= in_sentence_next;
      running_xor <= running_xor_next;
    end
  end

endmodule

/* hw/rtl/nsf_queue.sv */
// Short command queue between front and back ends.
`timescale 1ns / 1ps
module nsf_queue #(
  parameter int unsigned Depth = nsf_pkg::NSF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nsf_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output nsf_pkg::cmd_t head
);
  import nsf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

/* hw/rtl/nsf_back.sv */
// Back end: expands queued commands into sentence bytes, one per cycle while out_ready is high.
`timescale 1ns / 1ps
module nsf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  nsf_pkg::cmd_t head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          run_last
);
  import nsf_pkg::*;

  logic [2:0] idx;
  logic [7:0] gen_char;
  logic       gen_last;
  logic       advance;

  assign advance = !q_empty && (!out_valid || out_ready);
  assign q_pop   = advance && gen_last;

  always_comb begin
    gen_char = head.ch;
    gen_last = 1'b1;
    unique case (head.kind)
      CMD_HDR: begin
        gen_last = (idx == HDR_LAST_IDX);
        unique case (idx)
          3'd0:    gen_char = CH_DOLLAR;
          3'd1:    gen_char = head.talker[15:8];
          3'd2:    gen_char = head.talker[7:0];
          3'd3:    gen_char = head.sentence[23:16];
          3'd4:    gen_char = head.sentence[15:8];
          3'd5:    gen_char = head.sentence[7:0];
          default: gen_char = CH_COMMA;
        endcase
      end
      CMD_END: begin
        gen_last = (idx == END_LAST_IDX);
        unique case (idx)
          3'd0:    gen_char = CH_STAR;
          3'd1:    gen_char = hex_digit(head.ch[7:4]);
          3'd2:    gen_char = hex_digit(head.ch[3:0]);
          3'd3:    gen_char = CH_CR;
          default: gen_char = CH_LF;
        endcase
      end
      default: begin
        gen_char = head.ch;
        gen_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      idx       <= gen_last ? 3'd0 : idx + 3'd1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= gen_char;
      run_last <= gen_last;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst) idx <= HDR_LAST_IDX)
    else $error("byte index out of range");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (advance && !gen_last) |=> (idx == $past(idx) + 3'd1))
    else $error("byte index did not step");
  a_idx_wrap: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (idx == 3'd0))
    else $error("byte index not cleared after last byte");
`endif

endmodule

/* bench/tb_nmea_sentence_framer.sv */
// Self-checking testbench for the NMEA sentence framer: directed and random sentences.
`timescale 1ns / 1ps
module tb_nmea_sentence_framer;
  import nsf_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned ITEM_COUNT = 300;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } frame_byte_t;

  class sentence_tracker;
    frame_byte_t pending_bytes[$];
    logic [7:0]  csum;
    logic        sentence_open;
    int          n_bad;

    function new();
      csum = '0;
      sentence_open = 1'b0;
      n_bad = 0;
    endfunction

    function void push_byte(logic [7:0] ch, logic last);
      frame_byte_t b;
      b.ch = ch;
      b.last = last;
      pending_bytes.push_back(b);
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) begin
        return {4'd0, nib} + CH_ZERO;
      end
      return {4'd0, nib} - 8'd10 + CH_UPPER_A;
    endfunction

    // Expected bytes for one accepted transfer on the input side.
    function void take_item(logic [1:0] act, logic [15:0] talker, logic [23:0] stype,
                            logic [7:0] body);
      logic [7:0] hdr [6];
      int i;
      hdr[0] = talker[15:8];
      hdr[1] = talker[7:0];
      hdr[2] = stype[23:16];
      hdr[3] = stype[15:8];
      hdr[4] = stype[7:0];
      hdr[5] = CH_COMMA;
      case (act)
        ACT_BEGIN: begin
          push_byte(CH_DOLLAR, 1'b0);
          csum = '0;
          for (i = 0; i < 6; i++) begin
            csum ^= hdr[i];
            push_byte(hdr[i], i == 5);
          end
          sentence_open = 1'b1;
        end
        ACT_BODY: begin
          if (sentence_open) begin
            csum ^= body;
            push_byte(body, 1'b1);
          end
        end
        ACT_END: begin
          if (sentence_open) begin
            push_byte(CH_STAR, 1'b0);
            push_byte(hex_char(csum[7:4]), 1'b0);
            push_byte(hex_char(csum[3:0]), 1'b0);
            push_byte(CH_CR, 1'b0);
            push_byte(CH_LF, 1'b1);
            sentence_open = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] ch, logic last);
      frame_byte_t want;
      if (pending_bytes.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected byte %h run_last %b", ch, last);
      end else begin
        want = pending_bytes.pop_front();
        if (want.ch !== ch || want.last !== last) begin
          n_bad++;
          if (n_bad <= 10)
            $display("byte mismatch: expected %h/%b, got %h/%b", want.ch, want.last, ch, last);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [15:0] talker_chars = '0;
  logic [23:0] sentence_chars = '0;
  logic [7:0]  body_char = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        run_last;

  sentence_tracker tracker = new();
  int unsigned n_sent = 0;
  int unsigned idle_run = 0;
  bit          quiet = 1'b0;
  bit          held = 1'b0;

  nmea_sentence_framer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .talker_chars(talker_chars),
    .sentence_chars(sentence_chars),
    .body_char(body_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .run_last(run_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_item(input logic [1:0] act, input logic [15:0] tk,
                           input logic [23:0] st, input logic [7:0] bc);
    in_valid <= 1'b1;
    action <= act;
    talker_chars <= tk;
    sentence_chars <= st;
    body_char <= bc;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(act, tk, st, bc);
    n_sent++;
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_and_idle(input logic [1:0] act, input logic [15:0] tk,
                               input logic [23:0] st, input logic [7:0] bc);
    send_item(act, tk, st, bc);
    maybe_idle();
  endtask

  function automatic logic [7:0] header_char();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h41, 8'h5A));
    return 8'($urandom);
  endfunction

  task automatic random_sentence();
    int n_body;
    int k;
    n_body = $urandom_range(0, 12);
    send_and_idle(ACT_BEGIN, {header_char(), header_char()},
                  {header_char(), header_char(), header_char()}, 8'($urandom));
    for (k = 0; k < n_body; k++) begin
      send_and_idle(ACT_BODY, 16'($urandom), 24'($urandom), 8'($urandom_range(1, 255)));
    end
    // occasionally leave the sentence open so that a later begin may abandon it
    if ($urandom_range(0, 9) != 0)
      send_and_idle(ACT_END, 16'($urandom), 24'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_and_idle(ACT_END, 16'h0000, 24'h000000, 8'h00);
    send_and_idle(ACT_BODY, 16'hFFFF, 24'hFFFFFF, 8'h41);
    send_and_idle(ACT_SPARE, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    send_and_idle(ACT_BEGIN, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    send_and_idle(ACT_BODY, 16'h0000, 24'h000000, 8'h00);
    send_and_idle(ACT_BODY, 16'h0000, 24'h000000, CH_STAR);
    send_and_idle(ACT_BODY, 16'h0000, 24'h000000, 8'hFF);
    send_and_idle(ACT_BODY, 16'h0000, 24'h000000, 8'h01);
    send_and_idle(ACT_END, 16'h0000, 24'h000000, 8'h00);
    send_and_idle(ACT_BEGIN, 16'h0000, 24'h000000, 8'h00);
    send_and_idle(ACT_BODY, 16'h0000, 24'h000000, 8'h80);
    send_and_idle(ACT_BEGIN, 16'h4750, 24'h474741, 8'h00);
    send_and_idle(ACT_SPARE, 16'h0000, 24'h000000, 8'h55);
    send_and_idle(ACT_BODY, 16'h0000, 24'h000000, 8'h31);
    send_and_idle(ACT_BODY, 16'h0000, 24'h000000, 8'h2C);
    send_and_idle(ACT_END, 16'h0000, 24'h000000, 8'h00);
    send_and_idle(ACT_END, 16'h0000, 24'h000000, 8'h00);
    send_and_idle(ACT_BEGIN, 16'h5AA5, 24'hA55AA5, 8'h7F);
    send_and_idle(ACT_END, 16'hFFFF, 24'hFFFFFF, 8'hFF);

    while (n_sent < ITEM_COUNT) begin
      quiet = (n_sent >= ITEM_COUNT - 60);
      if ($urandom_range(0, 6) == 0)
        send_and_idle(2'($urandom_range(0, 3)), 16'($urandom), 24'($urandom),
                      8'($urandom_range(0, 255)));
      else
        random_sentence();
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.n_bad == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back up the queue, none at the end
  initial begin
    forever begin
      if (!held && n_sent >= 60) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_byte(out_char, run_last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

endmodule
